// ===== design/iort_pkg.sv =====
package iort_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned TagBits = 8;
  localparam int unsigned TagSpace = 2 ** TagBits;
  localparam int unsigned Capacity = (Depth < TagSpace) ? Depth : TagSpace;
  localparam int unsigned SlotBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Capacity + 1);

  localparam int unsigned TagFieldBits = 8;
  localparam int unsigned CntFieldBits = 5;

  typedef enum logic {
    OP_ENQ     = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STATUS_ENQ     = 3'd0,
    STATUS_RETIRE  = 3'd1,
    STATUS_DONE    = 3'd2,
    STATUS_INVALID = 3'd3,
    STATUS_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [TagFieldBits-1:0] tag;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [TagFieldBits-1:0] assigned_tag;
    logic [TagFieldBits-1:0] oldest_tag;
    logic [CntFieldBits-1:0] freed_count;
    logic [CntFieldBits-1:0] occupancy;
  } rsp_t;

endpackage

// ===== design/in_order_retire_tracker_unit.sv =====
// In-order retire tracker. Tags are handed out in order, entries may finish
// out of order, and entries are freed strictly in order.
// A command beat is taken on req_i when start_i is high and busy_o is low.
// An enqueue takes the tail tag, while a release either frees the oldest
// entry or marks a younger outstanding entry as done.
// Every beat gives exactly one result on rsp_o, marked by result_valid_o for
// a single cycle; the receiver cannot stall, so nothing is held back.
// Enqueues, refused commands, out-of-order releases and a release of the
// oldest tag that leaves the ring empty give their result in the cycle after
// the command beat, and a new beat may come in that same cycle.
// Otherwise a release of the oldest tag reads the pending flag memory at the
// new head, one entry per cycle, freeing done entries until it finds a
// pending one or the ring is empty, so up to 15 entries beyond the oldest
// are freed. The result is registered once the ring ends up empty or a
// pending entry stops the scan; the scan speed is set by the single read
// port of the flag memory.
// busy_o is high while that scan runs.
// Reset empties the ring and sets both head and tail to tag zero. The flag
// memory needs no clearing, because a flag is always written at enqueue
// before it can be read.
module in_order_retire_tracker_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  iort_pkg::req_t req_i,
  output logic          result_valid_o,
  output iort_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  logic [iort_pkg::TagBits-1:0]    head_q, head_d;
  logic [iort_pkg::TagBits-1:0]    tail_q, tail_d;
  logic [iort_pkg::CntBits-1:0]    cnt_q, cnt_d;
  logic [iort_pkg::CntBits-1:0]    freed_q, freed_d;
  logic                            valid_q, valid_d;
  iort_pkg::rsp_t                  rsp_q, rsp_d;

  logic                            mem_q [iort_pkg::Depth];
  logic                            rdata_q;
  logic                            we;
  logic [iort_pkg::SlotBits-1:0]   waddr;
  logic                            wdata;

  logic [iort_pkg::TagBits-1:0]    offset;
  logic                            invalid;
  iort_pkg::status_e               status;
  logic [iort_pkg::TagBits-1:0]    assigned;

  assign offset  = req_i.tag[iort_pkg::TagBits-1:0] - head_q;
  assign invalid = (cnt_q == '0) || (offset >= iort_pkg::TagBits'(cnt_q));

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    freed_d  = freed_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;
    we       = 1'b0;
    waddr    = tail_q[iort_pkg::SlotBits-1:0];
    wdata    = 1'b1;
    status   = iort_pkg::STATUS_INVALID;
    assigned = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          freed_d = '0;
          unique case (req_i.op)
            iort_pkg::OP_ENQ: begin
              valid_d = 1'b1;
              if (cnt_q >= iort_pkg::CntBits'(iort_pkg::Capacity)) begin
                status = iort_pkg::STATUS_FULL;
              end else begin
                we       = 1'b1;
                assigned = tail_q;
                tail_d   = tail_q + 1'b1;
                cnt_d    = cnt_q + 1'b1;
                status   = iort_pkg::STATUS_ENQ;
              end
            end
            iort_pkg::OP_RELEASE: begin
              if (invalid) begin
                valid_d = 1'b1;
                status  = iort_pkg::STATUS_INVALID;
              end else if (offset == '0) begin
                head_d  = head_q + 1'b1;
                cnt_d   = cnt_q - 1'b1;
                freed_d = iort_pkg::CntBits'(1);
                status  = iort_pkg::STATUS_RETIRE;
                if (cnt_d == '0) begin
                  valid_d = 1'b1;
                end else begin
                  state_d = ST_SCAN;
                end
              end else begin
                we      = 1'b1;
                waddr   = req_i.tag[iort_pkg::SlotBits-1:0];
                wdata   = 1'b0;
                valid_d = 1'b1;
                status  = iort_pkg::STATUS_DONE;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        status = iort_pkg::STATUS_RETIRE;
        if (!rdata_q) begin
          head_d  = head_q + 1'b1;
          cnt_d   = cnt_q - 1'b1;
          freed_d = freed_q + 1'b1;
          if (cnt_d == '0) begin
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (valid_d) begin
      rsp_d.status       = status;
      rsp_d.assigned_tag = iort_pkg::TagFieldBits'(assigned);
      rsp_d.oldest_tag   = iort_pkg::TagFieldBits'(head_d);
      rsp_d.freed_count  = iort_pkg::CntFieldBits'(freed_d);
      rsp_d.occupancy    = iort_pkg::CntFieldBits'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[head_d[iort_pkg::SlotBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      freed_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      freed_q <= freed_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy_o         = (state_q == ST_SCAN);
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

// ===== design/iort_checker.sv =====
module iort_sva (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input iort_pkg::req_t req_i,
  input logic           result_valid_o,
  input iort_pkg::rsp_t rsp_o
);

  // An enqueue beat is answered in the next cycle, as enqueued or full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.op == iort_pkg::OP_ENQ) |=>
      (result_valid_o && (rsp_o.status == iort_pkg::STATUS_ENQ ||
                          rsp_o.status == iort_pkg::STATUS_FULL)))
    else $error("enqueue beat not answered in the next cycle");

  // No result appears while a retire scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !result_valid_o)
    else $error("result shown while busy");

  // The block becomes busy only right after it takes a release beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> ($past(start_i) && $past(req_i.op) == iort_pkg::OP_RELEASE))
    else $error("busy without a release beat");

  // Entries are freed exactly when the oldest one retires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((rsp_o.status == iort_pkg::STATUS_RETIRE) == (rsp_o.freed_count != '0)))
    else $error("freed count does not match the status");

endmodule

bind in_order_retire_tracker_unit iort_sva u_iort_sva (.*);

// ===== sim/iort_checker.sv =====
`timescale 1ns / 1ps

module iort_checker
  import iort_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        result_valid_i,
  input  rsp_t        rsp_i,
  output int unsigned waiting_o,
  output int unsigned mismatches_o
);

  logic [Depth-1:0]   pend_flags;
  logic [TagBits-1:0] head_tag;
  logic [TagBits-1:0] tail_tag;
  int unsigned        live_cnt;

  rsp_t        expected_rsp[$];
  rsp_t        want;
  int unsigned err_cnt;

  function automatic void retire_head();
    pend_flags = pend_flags >> 1;
    head_tag   = head_tag + 1'b1;
    live_cnt   = live_cnt - 1;
  endfunction

  function automatic rsp_t track_command(req_t cmd);
    rsp_t               r;
    logic [TagBits-1:0] offset;
    int unsigned        freed;
    r      = '0;
    freed  = 0;
    offset = TagBits'(cmd.tag) - head_tag;
    if (cmd.op == OP_ENQ) begin
      if (live_cnt >= Capacity) begin
        r.status = STATUS_FULL;
      end else begin
        pend_flags[live_cnt] = 1'b1;
        r.assigned_tag       = TagFieldBits'(tail_tag);
        tail_tag             = tail_tag + 1'b1;
        live_cnt             = live_cnt + 1;
        r.status             = STATUS_ENQ;
      end
    end else if (live_cnt == 0 || offset >= live_cnt) begin
      r.status = STATUS_INVALID;
    end else if (offset == 0) begin
      retire_head();
      freed = 1;
      while (live_cnt > 0 && !pend_flags[0]) begin
        retire_head();
        freed++;
      end
      r.status = STATUS_RETIRE;
    end else begin
      pend_flags[offset] = 1'b0;
      r.status           = STATUS_DONE;
    end
    r.oldest_tag  = TagFieldBits'(head_tag);
    r.freed_count = CntFieldBits'(freed);
    r.occupancy   = CntFieldBits'(live_cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_flags = '0;
      head_tag   = '0;
      tail_tag   = '0;
      live_cnt   = 0;
      err_cnt    = 0;
      expected_rsp.delete();
      waiting_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // The result of an older beat may arrive in the same cycle as a new beat.
      if (result_valid_i) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d assigned=%0d oldest=%0d freed=%0d occ=%0d",
                   $time, rsp_i.status, rsp_i.assigned_tag, rsp_i.oldest_tag,
                   rsp_i.freed_count, rsp_i.occupancy);
          err_cnt++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_i !== want) begin
            $display("%0t: mismatch expected status=%0d assigned=%0d oldest=%0d freed=%0d occ=%0d",
                     $time, want.status, want.assigned_tag, want.oldest_tag,
                     want.freed_count, want.occupancy);
            $display("%0t:          actual   status=%0d assigned=%0d oldest=%0d freed=%0d occ=%0d",
                     $time, rsp_i.status, rsp_i.assigned_tag, rsp_i.oldest_tag,
                     rsp_i.freed_count, rsp_i.occupancy);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_rsp.push_back(track_command(req_i));
      end
      waiting_o    <= expected_rsp.size();
      mismatches_o <= err_cnt;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import iort_pkg::*;

  localparam int unsigned NumItems  = 1900;
  localparam int unsigned IdleLimit = 2000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic result_valid_o;
  rsp_t rsp_o;

  int unsigned waiting;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned sent;
  int unsigned fill_bias;
  logic        no_idle;

  logic [TagFieldBits-1:0] seen_oldest = '0;
  logic [CntFieldBits-1:0] seen_occ    = '0;

  always #5 clk_i = ~clk_i;

  in_order_retire_tracker_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  iort_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (req_i),
    .result_valid_i (result_valid_o),
    .rsp_i          (rsp_o),
    .waiting_o      (waiting),
    .mismatches_o   (mismatches)
  );

  always @(posedge clk_i) begin
    if (result_valid_o) begin
      seen_oldest <= rsp_o.oldest_tag;
      seen_occ    <= rsp_o.occupancy;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input op_e op, input logic [TagFieldBits-1:0] tag);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= req_t'{op: op, tag: tag};
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic drain_all();
    start_i <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
  endtask

  function automatic logic [TagFieldBits-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (seen_occ == 0 || r < 15) begin
      return TagFieldBits'($urandom_range(0, 255));
    end else if (r < 35) begin
      return seen_oldest;
    end
    return seen_oldest + TagFieldBits'($urandom_range(0, seen_occ - 1));
  endfunction

  // Fill the ring, mark every younger entry done in random order, then free the
  // oldest so that the whole ring retires in one scan.
  task automatic full_chain();
    int unsigned             order[Capacity];
    int unsigned             j;
    int unsigned             tmp;
    logic [TagFieldBits-1:0] base;
    drain_all();
    repeat (Capacity - seen_occ) send_cmd(OP_ENQ, TagFieldBits'($urandom));
    drain_all();
    base = seen_oldest;
    for (int unsigned k = 0; k < Capacity; k++) order[k] = k;
    for (int unsigned k = Capacity - 1; k > 1; k--) begin
      j        = $urandom_range(1, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int unsigned k = 1; k < Capacity; k++) begin
      send_cmd(OP_RELEASE, base + TagFieldBits'(order[k]));
    end
    send_cmd(OP_RELEASE, base);
  endtask

  initial begin
    sent      = 0;
    no_idle   = 1'b0;
    fill_bias = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(OP_RELEASE, 8'd0);
    send_cmd(OP_RELEASE, 8'd255);
    repeat (Capacity) send_cmd(OP_ENQ, 8'd255);
    send_cmd(OP_ENQ, 8'd0);
    send_cmd(OP_RELEASE, 8'd200);
    send_cmd(OP_RELEASE, 8'd3);
    send_cmd(OP_RELEASE, 8'd3);
    send_cmd(OP_RELEASE, 8'd1);
    send_cmd(OP_RELEASE, 8'd2);
    send_cmd(OP_RELEASE, 8'd0);
    drain_all();

    while (sent < NumItems) begin
      if (sent % 100 < 2) begin
        fill_bias = $urandom_range(20, 80);
        no_idle   = ($urandom_range(0, 3) == 0);
      end
      if (sent % 250 < 2) begin
        full_chain();
      end else if ($urandom_range(0, 99) < fill_bias) begin
        send_cmd(OP_ENQ, TagFieldBits'($urandom));
      end else begin
        send_cmd(OP_RELEASE, pick_tag());
      end
      if (sent == NumItems / 2) drain_all();
    end

    drain_all();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/iort_pkg.sv
design/in_order_retire_tracker_unit.sv
design/iort_checker.sv
sim/iort_checker.sv
sim/tb_top.sv
